// ===== design/tiu_pkg.sv =====
// ----------------------------------------------------------------------------
// tiu_pkg
// types, codes and constants shared by the tiny isa execute unit
// ----------------------------------------------------------------------------
package tiu_pkg;

  localparam int unsigned REG_COUNT   = 16;
  localparam int unsigned MEM_DEPTH   = 256;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned PC_W        = 10;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned REG_IDX_W   = $clog2(REG_COUNT);
  localparam int unsigned MEM_IDX_W   = $clog2(MEM_DEPTH);
  localparam int unsigned COST_W      = 4;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned IN_W        = 16;
  localparam int unsigned OUT_W       = 96;
  localparam int unsigned NIBBLE      = 4;
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [3:0] {
    OP_LD  = 4'd0,
    OP_ST  = 4'd1,
    OP_STI = 4'd2,
    OP_LDI = 4'd3,
    OP_ADD = 4'd4,
    OP_SUB = 4'd5,
    OP_JZ  = 4'd6
  } opcode_t;

  typedef enum logic [1:0] {
    WK_NONE = 2'd0,
    WK_REG  = 2'd1,
    WK_MEM  = 2'd2
  } write_kind_t;

  // decoded instruction plus operands read from the register file and memory
  typedef struct packed {
    logic [3:0]           opcode;
    logic [REG_IDX_W-1:0] reg_select;
    logic [7:0]           operand_byte;
    data_t                rs_data;
    data_t                rt_data;
    data_t                mem_data;
    logic [PC_W-1:0]      pc;
  } exec_in_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              branch_taken;
    write_kind_t       write_kind;
    logic [7:0]        write_index;
    data_t             write_value;
    logic              undefined_opcode;
    logic [COST_W-1:0] instr_cycles;
  } exec_out_t;

  function automatic logic [COST_W-1:0] op_cost(input logic [3:0] op);
    logic [COST_W-1:0] c;
    case (op)
      OP_LD:   c = 4'd4;
      OP_ST:   c = 4'd4;
      OP_STI:  c = 4'd8;
      OP_LDI:  c = 4'd6;
      OP_ADD:  c = 4'd7;
      OP_SUB:  c = 4'd7;
      OP_JZ:   c = 4'd15;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/tiu_exec.sv =====
// ----------------------------------------------------------------------------
// tiu_exec
// combinational execute of one instruction on already fetched operands
// ----------------------------------------------------------------------------
module tiu_exec (
  input  tiu_pkg::exec_in_t  ex_in,
  output tiu_pkg::exec_out_t ex_out
);

  logic [tiu_pkg::PC_W-1:0] pc_inc;
  logic [tiu_pkg::PC_W-1:0] pc_branch;
  tiu_pkg::data_t           imm;

  assign pc_inc    = ex_in.pc + {{(tiu_pkg::PC_W-1){1'b0}}, 1'b1};
  // 8-bit signed offset extended to the pc width, wraps modulo the 10-bit pc range
  assign pc_branch = pc_inc + {{(tiu_pkg::PC_W-8){ex_in.operand_byte[7]}},
                               ex_in.operand_byte};
  assign imm = {{(tiu_pkg::DATA_WIDTH-tiu_pkg::NIBBLE){ex_in.operand_byte[7]}},
                ex_in.operand_byte[7:4]};

  always_comb begin
    ex_out                  = '0;
    ex_out.next_pc          = pc_inc;
    ex_out.write_kind       = tiu_pkg::WK_NONE;
    ex_out.instr_cycles     = tiu_pkg::op_cost(ex_in.opcode);
    unique case (ex_in.opcode)
      tiu_pkg::OP_LD: begin
        ex_out.write_kind  = tiu_pkg::WK_REG;
        ex_out.write_index = 8'(ex_in.reg_select);
        ex_out.write_value = ex_in.mem_data;
      end
      tiu_pkg::OP_ST: begin
        ex_out.write_kind  = tiu_pkg::WK_MEM;
        ex_out.write_index = ex_in.operand_byte;
        ex_out.write_value = ex_in.rs_data;
      end
      tiu_pkg::OP_STI: begin
        ex_out.write_kind  = tiu_pkg::WK_MEM;
        ex_out.write_index = ex_in.rs_data[7:0];
        ex_out.write_value = ex_in.rt_data;
      end
      tiu_pkg::OP_LDI: begin
        ex_out.write_kind  = tiu_pkg::WK_REG;
        ex_out.write_index = 8'(ex_in.reg_select);
        ex_out.write_value = imm;
      end
      tiu_pkg::OP_ADD: begin
        ex_out.write_kind  = tiu_pkg::WK_REG;
        ex_out.write_index = 8'(ex_in.reg_select);
        ex_out.write_value = ex_in.rs_data + ex_in.rt_data;
      end
      tiu_pkg::OP_SUB: begin
        ex_out.write_kind  = tiu_pkg::WK_REG;
        ex_out.write_index = 8'(ex_in.reg_select);
        ex_out.write_value = ex_in.rs_data - ex_in.rt_data;
      end
      tiu_pkg::OP_JZ: begin
        if (ex_in.rs_data == '0) begin
          ex_out.branch_taken = 1'b1;
          ex_out.next_pc      = pc_branch;
        end
      end
      default: begin
        ex_out.undefined_opcode = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/tiny_isa_execute_unit.sv =====
// ----------------------------------------------------------------------------
// tiny_isa_execute_unit
// executes one instruction of a seven-opcode toy isa per word
// ----------------------------------------------------------------------------
// in_* carries one instruction word; out_* returns one result word for each.
// cfg_* writes program_length; cfg_ready is always high, write only when idle.
// an accepted word lands in an operand stage: at the accept edge the register
// file and data memory are read (two register ports, one memory port) with
// forwarding from the instruction executing at that same edge. the edge at
// which it leaves the operand stage executes it, updates state and loads the
// output register; one word is taken per cycle unless the output stalls.
// the operand stage and output register move together: when out_tready is
// low with a result waiting, the operand stage holds and in_tready drops once
// it is full. in_tready depends combinationally on out_tready.
// reset clears pc, cycle total, program_length (to 1024) and the valid bits
// of all 16 registers and 256 memory words, so every entry reads as zero
// right away with no clearing pass.
// ----------------------------------------------------------------------------
module tiny_isa_execute_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  // opcode[3:0], reg_select[7:4], operand_byte[15:8]
  input  logic [tiu_pkg::IN_W-1:0]  in_tdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // next_pc[9:0], halted[10], branch_taken[11], write_kind[13:12],
  // write_index[21:14], write_value[53:22], undefined_opcode[54],
  // instr_cycles[58:55], total_cycles[90:59], zero[95:91]
  output logic [tiu_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [tiu_pkg::LEN_W-1:0] cfg_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready
);

  localparam int unsigned RI = tiu_pkg::REG_IDX_W;
  localparam int unsigned MI = tiu_pkg::MEM_IDX_W;

  tiu_pkg::data_t rf_mem [tiu_pkg::REG_COUNT];
  tiu_pkg::data_t d_mem  [tiu_pkg::MEM_DEPTH];
  logic [tiu_pkg::REG_COUNT-1:0] rf_vld_r;
  logic [tiu_pkg::MEM_DEPTH-1:0] dm_vld_r;

  logic [tiu_pkg::LEN_W-1:0]   prog_len_r;
  logic [tiu_pkg::PC_W-1:0]    pc_r;
  logic [tiu_pkg::TOTAL_W-1:0] total_r;
  logic [tiu_pkg::TOTAL_W-1:0] total_nxt;

  // operand stage
  logic                 s1_vld_r;
  logic [3:0]           s1_op_r;
  logic [RI-1:0]        s1_rs_r;
  logic [7:0]           s1_ob_r;
  tiu_pkg::data_t       s1_rs_data_r;
  tiu_pkg::data_t       s1_rt_data_r;
  tiu_pkg::data_t       s1_mem_data_r;

  // output register
  logic                 out_vld_r;
  tiu_pkg::exec_out_t   res_r;
  logic                 halted_r;
  logic [tiu_pkg::TOTAL_W-1:0] out_total_r;

  logic                 in_fire;
  logic                 s1_fire;
  logic [RI-1:0]        in_rs;
  logic [RI-1:0]        in_rt;
  logic [MI-1:0]        in_addr;
  logic                 wr_reg;
  logic                 wr_mem;
  logic [RI-1:0]        wr_ridx;
  logic [MI-1:0]        wr_midx;

  tiu_pkg::exec_in_t    ex_in;
  tiu_pkg::exec_out_t   ex_out;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  assign in_rs   = in_tdata[7:4];
  assign in_rt   = in_tdata[15:12];
  assign in_addr = in_tdata[15:8];

  assign ex_in.opcode       = s1_op_r;
  assign ex_in.reg_select   = s1_rs_r;
  assign ex_in.operand_byte = s1_ob_r;
  assign ex_in.rs_data      = s1_rs_data_r;
  assign ex_in.rt_data      = s1_rt_data_r;
  assign ex_in.mem_data     = s1_mem_data_r;
  assign ex_in.pc           = pc_r;

  tiu_exec u_exec (
    .ex_in  (ex_in),
    .ex_out (ex_out)
  );

  assign wr_reg    = s1_fire && (ex_out.write_kind == tiu_pkg::WK_REG);
  assign wr_mem    = s1_fire && (ex_out.write_kind == tiu_pkg::WK_MEM);
  assign wr_ridx   = ex_out.write_index[RI-1:0];
  assign wr_midx   = ex_out.write_index[MI-1:0];
  assign total_nxt = total_r + {{(tiu_pkg::TOTAL_W-tiu_pkg::COST_W){1'b0}},
                                ex_out.instr_cycles};

  // storage writes
  always_ff @(posedge clk) begin
    if (wr_reg) begin
      rf_mem[wr_ridx] <= ex_out.write_value;
    end
    if (wr_mem) begin
      d_mem[wr_midx] <= ex_out.write_value;
    end
  end

  // operand reads at accept, forwarding the write of the same edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r <= in_tdata[3:0];
      s1_rs_r <= in_rs;
      s1_ob_r <= in_tdata[15:8];
      if (wr_reg && (wr_ridx == in_rs)) begin
        s1_rs_data_r <= ex_out.write_value;
      end else if (rf_vld_r[in_rs]) begin
        s1_rs_data_r <= rf_mem[in_rs];
      end else begin
        s1_rs_data_r <= '0;
      end
      if (wr_reg && (wr_ridx == in_rt)) begin
        s1_rt_data_r <= ex_out.write_value;
      end else if (rf_vld_r[in_rt]) begin
        s1_rt_data_r <= rf_mem[in_rt];
      end else begin
        s1_rt_data_r <= '0;
      end
      if (wr_mem && (wr_midx == in_addr)) begin
        s1_mem_data_r <= ex_out.write_value;
      end else if (dm_vld_r[in_addr]) begin
        s1_mem_data_r <= d_mem[in_addr];
      end else begin
        s1_mem_data_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r       <= ex_out;
      halted_r    <= ({1'b0, ex_out.next_pc} >= prog_len_r);
      out_total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r   <= '0;
      dm_vld_r   <= '0;
      prog_len_r <= tiu_pkg::LEN_RESET;
      pc_r       <= '0;
      total_r    <= '0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        prog_len_r <= cfg_data;
      end
      if (wr_reg) begin
        rf_vld_r[wr_ridx] <= 1'b1;
      end
      if (wr_mem) begin
        dm_vld_r[wr_midx] <= 1'b1;
      end
      if (s1_fire) begin
        pc_r    <= ex_out.next_pc;
        total_r <= total_nxt;
      end
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s1_fire) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_total_r, res_r.instr_cycles, res_r.undefined_opcode,
                       res_r.write_value, res_r.write_index, res_r.write_kind,
                       res_r.branch_taken, halted_r, res_r.next_pc};

  // a full operand stage that cannot drain blocks new words
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_fire) |-> !in_tready)
    else $error("operand stage overwritten while stalled");

  a_exec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_vld_r)
    else $error("executed word missing from output register");

  a_total_acc: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (total_r == $past(total_r) + 32'($past(ex_out.instr_cycles))))
    else $error("cycle total did not accumulate instruction cost");

  a_undef_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && ex_out.undefined_opcode) |->
      (ex_out.write_kind == tiu_pkg::WK_NONE && ex_out.instr_cycles == '0 &&
       !ex_out.branch_taken))
    else $error("undefined opcode changed state");

  a_taken_is_jump: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && ex_out.branch_taken) |-> (s1_op_r == tiu_pkg::OP_JZ))
    else $error("branch taken on a non-jump opcode");

endmodule

// ===== tb/sv/tb_tiny_isa_execute_unit.sv =====
// ----------------------------------------------------------------------------
// tb_tiny_isa_execute_unit
// self-checking bench for the tiny isa execute unit
// ----------------------------------------------------------------------------
// instruction words are run through a local model of the unit (registers,
// data memory, pc and cycle total) as they are accepted. each result word is
// checked field by field against the oldest prediction. the run opens with
// hand-picked instructions, then random instruction mixes under several
// program lengths. the sender bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_tiny_isa_execute_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT = 400000;

  // result word layout, lowest field last
  typedef struct packed {
    logic [4:0]                 pad;
    logic [31:0]                total;
    logic [tiu_pkg::COST_W-1:0] cost;
    logic                       undef;
    tiu_pkg::data_t             wval;
    logic [7:0]                 widx;
    tiu_pkg::write_kind_t       kind;
    logic                       taken;
    logic                       halted;
    logic [tiu_pkg::PC_W-1:0]   next_pc;
  } exec_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic [tiu_pkg::IN_W-1:0]  in_tdata = '0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [tiu_pkg::OUT_W-1:0] out_tdata;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [tiu_pkg::LEN_W-1:0] cfg_data = '0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;

  tiny_isa_execute_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  tiu_pkg::data_t             gpr [tiu_pkg::REG_COUNT];
  tiu_pkg::data_t             dmem [tiu_pkg::MEM_DEPTH];
  logic [tiu_pkg::PC_W-1:0]   pc_now;
  logic [31:0]                cycle_sum;
  logic [tiu_pkg::LEN_W-1:0]  prog_len;
  logic [tiu_pkg::COST_W-1:0] step_cost [7] =
    '{4'd4, 4'd4, 4'd8, 4'd6, 4'd7, 4'd7, 4'd15};

  logic [tiu_pkg::IN_W-1:0]  instr_queue [$];
  exec_result_t              results_due [$];

  int errors = 0;
  int words_checked = 0;
  int n_taken = 0;
  int n_halted = 0;
  int n_undef = 0;
  int n_lengths = 0;
  int unsigned cycle_count = 0;

  function automatic logic [tiu_pkg::IN_W-1:0] pack_instr(input logic [3:0] op,
                                                          input logic [3:0] rs,
                                                          input logic [7:0] ob);
    return {ob, rs, op};
  endfunction

  // runs one instruction word on the model and queues what the unit must return
  function automatic void execute_word(input logic [tiu_pkg::IN_W-1:0] w);
    logic [3:0]               op;
    logic [3:0]               rs;
    logic [3:0]               rt;
    logic [7:0]               ob;
    logic [tiu_pkg::PC_W-1:0] step;
    exec_result_t             r;
    op = w[3:0];
    rs = w[7:4];
    ob = w[15:8];
    rt = ob[7:4];
    r = '0;
    step = 10'd1;
    case (op)
      tiu_pkg::OP_LD: begin
        r.kind = tiu_pkg::WK_REG;
        r.widx = 8'(rs);
        r.wval = dmem[ob];
      end
      tiu_pkg::OP_ST: begin
        r.kind = tiu_pkg::WK_MEM;
        r.widx = ob;
        r.wval = gpr[rs];
      end
      tiu_pkg::OP_STI: begin
        r.kind = tiu_pkg::WK_MEM;
        r.widx = gpr[rs][7:0];
        r.wval = gpr[rt];
      end
      tiu_pkg::OP_LDI: begin
        r.kind = tiu_pkg::WK_REG;
        r.widx = 8'(rs);
        r.wval = {{(tiu_pkg::DATA_WIDTH-4){ob[7]}}, ob[7:4]};
      end
      tiu_pkg::OP_ADD: begin
        r.kind = tiu_pkg::WK_REG;
        r.widx = 8'(rs);
        r.wval = gpr[rs] + gpr[rt];
      end
      tiu_pkg::OP_SUB: begin
        r.kind = tiu_pkg::WK_REG;
        r.widx = 8'(rs);
        r.wval = gpr[rs] - gpr[rt];
      end
      tiu_pkg::OP_JZ: begin
        if (gpr[rs] == '0) begin
          r.taken = 1'b1;
          step = 10'd1 + {{(tiu_pkg::PC_W-8){ob[7]}}, ob};
        end
      end
      default: r.undef = 1'b1;
    endcase
    if (r.kind == tiu_pkg::WK_REG) gpr[r.widx[3:0]] = r.wval;
    else if (r.kind == tiu_pkg::WK_MEM) dmem[r.widx] = r.wval;
    if (!r.undef) r.cost = step_cost[op];
    cycle_sum = cycle_sum + 32'(r.cost);
    pc_now = pc_now + step;
    r.next_pc = pc_now;
    r.halted = ({1'b0, pc_now} >= prog_len);
    r.total = cycle_sum;
    results_due.push_back(r);
    n_taken += r.taken;
    n_halted += r.halted;
    n_undef += r.undef;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc_now = '0;
      cycle_sum = '0;
      prog_len = tiu_pkg::LEN_RESET;
    end else begin
      if (in_tvalid && in_tready) execute_word(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || instr_queue.size() == 0) begin
          in_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_tdata <= instr_queue.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 300)
                                                     : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 5);
          end
        end
      end
    end
  end

  // receiver: stall style changes at random
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;
  exec_result_t want_r;
  exec_result_t got_r;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result word with nothing expected, got %h", $time, out_tdata);
          errors++;
        end else begin
          want_r = results_due.pop_front();
          got_r = exec_result_t'(out_tdata);
          check_field("next_pc", 32'(want_r.next_pc), 32'(got_r.next_pc));
          check_field("halted", 32'(want_r.halted), 32'(got_r.halted));
          check_field("branch_taken", 32'(want_r.taken), 32'(got_r.taken));
          check_field("write_kind", 32'(want_r.kind), 32'(got_r.kind));
          check_field("write_index", 32'(want_r.widx), 32'(got_r.widx));
          check_field("write_value", want_r.wval, got_r.wval);
          check_field("undefined_opcode", 32'(want_r.undef), 32'(got_r.undef));
          check_field("instr_cycles", 32'(want_r.cost), 32'(got_r.cost));
          check_field("total_cycles", want_r.total, got_r.total);
          check_field("pad", 32'(want_r.pad), 32'(got_r.pad));
          words_checked++;
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 300);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= (rx_tick % 5 < 2);
        default: out_tready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, results_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_length(input logic [tiu_pkg::LEN_W-1:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    prog_len = v;
    cfg_valid <= 1'b0;
    n_lengths++;
  endtask

  // waits until every word went out and came back, then lets the pipe settle
  task automatic wait_drained();
    do @(negedge clk);
    while (instr_queue.size() != 0 || in_tvalid || results_due.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic queue_directed();
    instr_queue.push_back(pack_instr(tiu_pkg::OP_LDI, 4'd0, 8'h7F));  // +7, junk low nibble
    instr_queue.push_back(pack_instr(tiu_pkg::OP_LDI, 4'd15, 8'h80)); // most negative immediate
    instr_queue.push_back(pack_instr(tiu_pkg::OP_LDI, 4'd1, 8'hF0));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_JZ, 4'd2, 8'h80));   // taken, wraps below zero
    instr_queue.push_back(pack_instr(tiu_pkg::OP_ADD, 4'd1, 8'hF0));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_SUB, 4'd2, 8'h00));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_ST, 4'd1, 8'hFF));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_ST, 4'd15, 8'h00));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_LD, 4'd3, 8'hFF));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_LD, 4'd4, 8'h80));
    // indirect stores use only the low byte of a negative register
    instr_queue.push_back(pack_instr(tiu_pkg::OP_STI, 4'd1, 8'h00));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_STI, 4'd15, 8'hF0));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_JZ, 4'd0, 8'h7F));   // not taken
    instr_queue.push_back(pack_instr(tiu_pkg::OP_JZ, 4'd5, 8'h7F));   // taken, farthest forward
    instr_queue.push_back(pack_instr(4'd7, 4'd9, 8'hAA));
    instr_queue.push_back(pack_instr(4'd15, 4'd15, 8'hFF));
    instr_queue.push_back(pack_instr(4'd8, 4'd0, 8'h00));
    instr_queue.push_back(pack_instr(4'd12, 4'd3, 8'h5A));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_SUB, 4'd6, 8'h10));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_LD, 4'd14, 8'hF7));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_ADD, 4'd14, 8'hEE));
    instr_queue.push_back(pack_instr(tiu_pkg::OP_JZ, 4'd2, 8'h80));
  endtask

  // random mix with short idioms so memory reads hit written words
  // and jumps find zero registers
  task automatic queue_random(input int n);
    int k;
    logic [3:0] r;
    logic [3:0] t;
    logic [7:0] a;
    k = 0;
    while (k < n) begin
      r = 4'($urandom);
      t = 4'($urandom);
      a = 8'($urandom_range(0, 15));
      if ($urandom_range(0, 1) == 1) a = ~a;
      if ($urandom_range(0, 2) == 0) a = 8'($urandom);
      case ($urandom_range(0, 9))
        0: begin
          instr_queue.push_back(pack_instr(tiu_pkg::OP_SUB, r, {r, 4'($urandom)}));
          instr_queue.push_back(pack_instr(tiu_pkg::OP_JZ, r, 8'($urandom)));
          k += 2;
        end
        1: begin
          instr_queue.push_back(pack_instr(tiu_pkg::OP_ST, r, a));
          instr_queue.push_back(pack_instr(tiu_pkg::OP_LD, t, a));
          k += 2;
        end
        2: begin
          // doubling pushes values toward wraparound
          instr_queue.push_back(pack_instr(tiu_pkg::OP_ADD, r, {r, 4'($urandom)}));
          k++;
        end
        3: begin
          instr_queue.push_back(pack_instr(4'($urandom_range(7, 15)), r, 8'($urandom)));
          k++;
        end
        default: begin
          instr_queue.push_back(pack_instr(4'($urandom_range(0, 6)), r,
                                           ($urandom_range(0, 1) == 1) ? a : 8'($urandom)));
          k++;
        end
      endcase
    end
  endtask

  logic [tiu_pkg::LEN_W-1:0] len_settings [7];

  initial begin
    len_settings = '{11'd1, 11'd0, 11'd2047, 11'd1023, 11'd1024, 11'd16, 11'd0};
    len_settings[6] = 11'($urandom_range(2, 1022));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_directed();
    queue_random(240);
    wait_drained();
    foreach (len_settings[i]) begin
      write_length(len_settings[i]);
      @(negedge clk);
      queue_random(220);
      wait_drained();
    end
    $display("ran %0d instructions over %0d program lengths after reset", words_checked,
             n_lengths);
    $display("%0d jumps taken, %0d halted results, %0d undefined codes, %0d mismatches",
             n_taken, n_halted, n_undef, errors);
    if (errors == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
